@@ sv/lzssd_pkg.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// LZSS stream decoder package
// Shared sizes, payload structs, control codes and state types.
// ---------------------------------------------------------------------------
package lzssd_pkg;

   localparam int HISTORY_DEPTH = 4096;
   localparam int HIST_AW       = $clog2(HISTORY_DEPTH);
   localparam int PROD_W        = $clog2(HISTORY_DEPTH + 1);

   localparam int          SLOTS_PER_GROUP = 16;
   localparam logic [7:0]  CTRL_LEN_MASK   = 8'h0F;
   localparam logic [7:0]  CTRL_DIST_MASK  = 8'hF0;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       stream_end;
   } req_data_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       run_last;
   } rsp_data_type;

   typedef struct packed {
      logic               en;
      logic [HIST_AW-1:0] addr;
      logic [7:0]         data;
   } hist_wr_type;

   typedef enum logic [1:0] {
      PH_FLAG0,
      PH_FLAG1,
      PH_SLOT,
      PH_CTRL2
   } phase_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LIT,
      ST_CALC,
      ST_ADDR,
      ST_READ,
      ST_EMIT
   } state_type;

endpackage
`default_nettype wire

@@ sv/lzssd_history.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// LZSS history window
// One write port and one registered read port over the decoded-byte window.
// ---------------------------------------------------------------------------
module lzssd_history (
   input  wire logic                         clock,
   input  wire lzssd_pkg::hist_wr_type       wr,
   input  wire logic                         rd_en,
   input  wire logic [lzssd_pkg::HIST_AW-1:0] rd_addr,
   output logic [7:0]                        rd_data
);
   import lzssd_pkg::*;

   logic [7:0] mem [HISTORY_DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

@@ sv/lzss_stream_decoder_top.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// LZSS stream decoder, top level
// Decodes one compressed byte per transfer into zero or more output bytes.
// ---------------------------------------------------------------------------
// Sequence: a flag byte or first control byte is taken in ST_IDLE; a literal
//   goes through ST_LIT to its output transfer; a copy goes through ST_CALC,
//   then unless skipped ST_ADDR, a read (ST_READ) and emit (ST_EMIT) per byte.
// Throughput: one item at a time; history reads and rsp_ready pace a copy.
// Reset: control state, the write pointer and output valid clear at once; the
//   history window is not cleared, since copies only read bytes of this stream.
// ---------------------------------------------------------------------------
module lzss_stream_decoder_top (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire lzssd_pkg::req_data_type req_data,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output lzssd_pkg::rsp_data_type      rsp_data
);
   import lzssd_pkg::*;

   localparam logic [HIST_AW:0]  DEPTH_W  = (HIST_AW + 1)'(HISTORY_DEPTH);
   localparam logic [PROD_W-1:0] PROD_MAX = PROD_W'(HISTORY_DEPTH);
   localparam logic [4:0]        SLOTS_W  = 5'(SLOTS_PER_GROUP);

   // sequencer and stream state
   state_type          state_ff, state_in;
   phase_type          phase_ff, phase_in;
   logic [15:0]        flag_ff, flag_in;
   logic [4:0]         slot_ff, slot_in;
   logic [7:0]         hold_ctrl_ff, hold_ctrl_in;
   logic [7:0]         byte_ff, byte_in;
   logic               end_ff, end_in;
   logic [HIST_AW-1:0] wp_ff, wp_in;
   logic [PROD_W-1:0]  prod_ff, prod_in;
   // copy run state
   logic [HIST_AW-1:0] src_ff, src_in;
   logic [4:0]         cnt_ff, cnt_in;
   logic [11:0]        eff_ff, eff_in;
   // output register
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_data_type       rsp_data_ff, rsp_data_in;

   hist_wr_type        hist_wr;
   logic               hist_rd_en;
   logic [7:0]         hist_rd_data;

   logic               req_fire;
   logic               rsp_free;
   logic               rsp_load;
   logic [4:0]         slot_adv;
   logic [11:0]        copy_dist;
   logic [4:0]         len;
   logic [PROD_W:0]    dist_ext;
   logic [PROD_W:0]    prod_ext;
   logic [PROD_W:0]    gap;
   logic [HIST_AW:0]   src_diff;
   logic [HIST_AW:0]   src_wrap;

   function automatic logic [HIST_AW-1:0] ptr_inc(input logic [HIST_AW-1:0] p);
      ptr_inc = (p == HIST_AW'(HISTORY_DEPTH - 1)) ? '0 : p + HIST_AW'(1);
   endfunction

   lzssd_history u_history (
      .clock   (clock),
      .wr      (hist_wr),
      .rd_en   (hist_rd_en),
      .rd_addr (src_ff),
      .rd_data (hist_rd_data)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   // the output register may take a byte when empty or being drained
   assign rsp_free  = !rsp_valid_ff || rsp_ready;

   assign slot_adv = slot_ff + 5'd1;

   // copy command fields: length from the low nibble, distance from the
   // high nibble and the second control byte
   assign copy_dist = {hold_ctrl_ff[7:4] & CTRL_DIST_MASK[7:4], byte_ff};
   assign len       = {1'b0, hold_ctrl_ff[3:0] & CTRL_LEN_MASK[3:0]} + 5'd1;
   assign dist_ext  = (PROD_W + 1)'(copy_dist);
   assign prod_ext  = {1'b0, prod_ff};
   assign gap       = dist_ext - prod_ext;

   // first source slot, wrapped back into the window
   assign src_diff = {1'b0, wp_ff} - (HIST_AW + 1)'(eff_ff);
   assign src_wrap = src_diff + DEPTH_W;

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      flag_in      = flag_ff;
      slot_in      = slot_ff;
      hold_ctrl_in = hold_ctrl_ff;
      byte_in      = byte_ff;
      end_in       = end_ff;
      wp_in        = wp_ff;
      prod_in      = prod_ff;
      src_in       = src_ff;
      cnt_in       = cnt_ff;
      eff_in       = eff_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_load     = 1'b0;
      hist_rd_en   = 1'b0;
      hist_wr.en   = 1'b0;
      hist_wr.addr = wp_ff;
      hist_wr.data = hist_rd_data;

      // drop the held result once it is taken
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               byte_in = req_data.in_byte;
               end_in  = req_data.stream_end;
               case (phase_ff)
                  PH_FLAG0: begin
                     flag_in  = {8'h00, req_data.in_byte};
                     phase_in = PH_FLAG1;
                  end
                  PH_FLAG1: begin
                     flag_in  = {req_data.in_byte, flag_ff[7:0]};
                     slot_in  = '0;
                     phase_in = PH_SLOT;
                  end
                  PH_SLOT: begin
                     if (!flag_ff[slot_ff[3:0]]) begin
                        state_in = ST_LIT;
                     end else begin
                        hold_ctrl_in = req_data.in_byte;
                        phase_in     = PH_CTRL2;
                     end
                  end
                  PH_CTRL2: begin
                     state_in = ST_CALC;
                  end
                  default: begin
                     phase_in = PH_FLAG0;
                  end
               endcase
               // items that finish here apply the end of stream at once
               if (req_data.stream_end && phase_ff != PH_CTRL2 &&
                   !(phase_ff == PH_SLOT && !flag_ff[slot_ff[3:0]])) begin
                  phase_in     = PH_FLAG0;
                  flag_in      = '0;
                  slot_in      = '0;
                  hold_ctrl_in = '0;
                  wp_in        = '0;
                  prod_in      = '0;
               end
            end
         end

         ST_LIT: begin
            if (rsp_free) begin
               rsp_load     = 1'b1;
               hist_wr.en   = 1'b1;
               hist_wr.data = byte_ff;
               rsp_data_in  = '{out_byte: byte_ff, run_last: 1'b1};
               wp_in        = ptr_inc(wp_ff);
               prod_in      = (prod_ff == PROD_MAX) ? prod_ff : prod_ff + PROD_W'(1);
               state_in     = ST_IDLE;
            end
         end

         ST_CALC: begin
            // skip a zero-distance copy and the copy bytes whose source lies before the stream start
            if (copy_dist == '0) begin
               state_in = ST_IDLE;
            end else if (dist_ext > prod_ext) begin
               if (gap >= (PROD_W + 1)'(len)) begin
                  state_in = ST_IDLE;
               end else begin
                  cnt_in   = len - gap[4:0];
                  eff_in   = prod_ff[11:0];
                  state_in = ST_ADDR;
               end
            end else begin
               cnt_in   = len;
               eff_in   = copy_dist;
               state_in = ST_ADDR;
            end
         end

         ST_ADDR: begin
            src_in   = src_diff[HIST_AW] ? src_wrap[HIST_AW-1:0] : src_diff[HIST_AW-1:0];
            state_in = ST_READ;
         end

         ST_READ: begin
            hist_rd_en = 1'b1;
            state_in   = ST_EMIT;
         end

         ST_EMIT: begin
            if (rsp_free) begin
               rsp_load    = 1'b1;
               hist_wr.en  = 1'b1;
               rsp_data_in = '{out_byte: hist_rd_data, run_last: (cnt_ff == 5'd1)};
               wp_in       = ptr_inc(wp_ff);
               prod_in     = (prod_ff == PROD_MAX) ? prod_ff : prod_ff + PROD_W'(1);
               src_in      = ptr_inc(src_ff);
               cnt_in      = cnt_ff - 5'd1;
               state_in    = (cnt_ff == 5'd1) ? ST_IDLE : ST_READ;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end

      // literal or copy done: advance the slot, then apply end of stream
      if ((state_ff == ST_CALC && state_in == ST_IDLE) ||
          ((state_ff == ST_LIT || state_ff == ST_EMIT) && state_in == ST_IDLE)) begin
         if (slot_adv >= SLOTS_W) begin
            slot_in  = '0;
            phase_in = PH_FLAG0;
         end else begin
            slot_in  = slot_adv;
            phase_in = PH_SLOT;
         end
         if (end_ff) begin
            phase_in     = PH_FLAG0;
            flag_in      = '0;
            slot_in      = '0;
            hold_ctrl_in = '0;
            wp_in        = '0;
            prod_in      = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= PH_FLAG0;
         flag_ff      <= '0;
         slot_ff      <= '0;
         hold_ctrl_ff <= '0;
         end_ff       <= 1'b0;
         wp_ff        <= '0;
         prod_ff      <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         flag_ff      <= flag_in;
         slot_ff      <= slot_in;
         hold_ctrl_ff <= hold_ctrl_in;
         end_ff       <= end_in;
         wp_ff        <= wp_in;
         prod_ff      <= prod_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers hold without reset
   always_ff @(posedge clock) begin
      byte_ff     <= byte_in;
      src_ff      <= src_in;
      eff_ff      <= eff_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // every byte written to the window is also the byte sent out
   a_wr_with_emit: assert property (@(posedge clock) disable iff (reset)
      hist_wr.en |-> rsp_load)
      else $error("history write without an output byte");

   a_run_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ || state_ff == ST_EMIT) |-> (cnt_ff != 5'd0))
      else $error("copy run active with zero count");

   a_group_start: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_FLAG0) |-> (slot_ff == 5'd0))
      else $error("group start with nonzero slot");

   a_prod_sat: assert property (@(posedge clock) disable iff (reset)
      prod_ff <= PROD_MAX)
      else $error("produced count beyond window depth");

endmodule
`default_nettype wire
